FILE: sv/zbpa_pkg.sv
`timescale 1ns / 1ps

package zbpa_pkg;

    localparam int PAGE_BITS_DEF = 20;
    localparam int TOP_ORDER_DEF = 10;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 20;
    localparam int COUNT_W  = 21;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DROP    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_ADDREF  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'd1;

    typedef enum logic [4:0] {
        CMD_CLEAR,
        CMD_IDLE,
        CMD_DISPATCH,
        CMD_RC_UPDATE,
        CMD_FH_READ,
        CMD_FH_MARK,
        CMD_RR_CHECK,
        CMD_RR_CLEAR,
        CMD_RR_NEXT,
        CMD_MI_CHECK,
        CMD_MI_TEST,
        CMD_MI_ADVANCE,
        CMD_UNLINK,
        CMD_PUSH_HEAD,
        CMD_PUSH_LINK,
        CMD_TF_START,
        CMD_TF_SCAN,
        CMD_TF_SPLIT,
        CMD_RUN_ORDER,
        CMD_RUN_NEXT,
        CMD_TF_MARK,
        CMD_DONE
    } cmd_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RC_UPDATE,
        S_FH_READ,
        S_FH_MARK,
        S_RR_CHECK,
        S_RR_CLEAR,
        S_RR_NEXT,
        S_MI_CHECK,
        S_MI_TEST,
        S_MI_ADVANCE,
        S_UNLINK,
        S_PUSH_HEAD,
        S_PUSH_LINK,
        S_TF_START,
        S_TF_SCAN,
        S_TF_SPLIT,
        S_RUN_ORDER,
        S_RUN_NEXT,
        S_TF_MARK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MRET_DONE,
        MRET_RANGE,
        MRET_RUN
    } merge_ret_t;

    typedef enum logic {
        URET_MERGE,
        URET_TAKE
    } unlink_ret_t;

    typedef enum logic {
        PRET_MERGE,
        PRET_SPLIT
    } push_ret_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic clr_last;
        logic bad_alloc;
        logic idx_out;
        logic cnt_zero;
        logic rc_zero;
        logic rc_one;
        logic rr_end;
        logic ri_in;
        logic mi_stop;
        logic mk_match;
        logic to_over;
        logic head_empty;
        logic can_fall;
        logic split_more;
        logic need_run;
        logic run_grow;
        logic run_last;
        logic mark_last;
        logic out_free;
    } dp_flags_t;

endpackage

FILE: sv/zbpa_controller.sv
`timescale 1ns / 1ps

module zbpa_controller
    import zbpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_flags_t flags,
    output cmd_t      cmd
);

    state_t      state_reg, state_next;
    merge_ret_t  mret_reg, mret_next;
    unlink_ret_t uret_reg, uret_next;
    push_ret_t   pret_reg, pret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            mret_reg  <= MRET_DONE;
            uret_reg  <= URET_MERGE;
            pret_reg  <= PRET_MERGE;
        end else begin
            state_reg <= state_next;
            mret_reg  <= mret_next;
            uret_reg  <= uret_next;
            pret_reg  <= pret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mret_next  = mret_reg;
        uret_next  = uret_reg;
        pret_next  = pret_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (flags.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (flags.func)
                    FN_ALLOC:   state_next = flags.bad_alloc ? S_DONE : S_TF_START;
                    FN_RELEASE: state_next = flags.cnt_zero ? S_DONE : S_RR_CHECK;
                    default:    state_next = flags.idx_out ? S_DONE : S_RC_UPDATE;
                endcase
            end
            S_RC_UPDATE: begin
                if (!flags.rc_zero && flags.func == FN_DROP && flags.rc_one) begin
                    state_next = S_FH_READ;
                    mret_next  = MRET_DONE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FH_READ:  state_next = S_FH_MARK;
            S_FH_MARK:  state_next = S_MI_CHECK;
            S_RR_CHECK: begin
                priority if (flags.rr_end) state_next = S_DONE;
                else if (!flags.ri_in)    state_next = S_RR_NEXT;
                else                      state_next = S_RR_CLEAR;
            end
            S_RR_CLEAR: begin
                if (flags.rc_zero) begin
                    state_next = S_RR_NEXT;
                end else begin
                    state_next = S_FH_READ;
                    mret_next  = MRET_RANGE;
                end
            end
            S_RR_NEXT: state_next = S_RR_CHECK;
            S_MI_CHECK: begin
                if (flags.mi_stop) begin
                    state_next = S_PUSH_HEAD;
                    pret_next  = PRET_MERGE;
                end else begin
                    state_next = S_MI_TEST;
                end
            end
            S_MI_TEST: begin
                if (flags.mk_match) begin
                    state_next = S_UNLINK;
                    uret_next  = URET_MERGE;
                end else begin
                    state_next = S_PUSH_HEAD;
                    pret_next  = PRET_MERGE;
                end
            end
            S_MI_ADVANCE: state_next = S_MI_CHECK;
            S_UNLINK: begin
                state_next = (uret_reg == URET_TAKE) ? S_TF_SPLIT : S_MI_ADVANCE;
            end
            S_PUSH_HEAD: state_next = S_PUSH_LINK;
            S_PUSH_LINK: begin
                if (pret_reg == PRET_SPLIT) begin
                    state_next = S_TF_SPLIT;
                end else begin
                    unique case (mret_reg)
                        MRET_RANGE: state_next = S_RR_NEXT;
                        MRET_RUN:   state_next = S_RUN_NEXT;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_TF_START: state_next = S_TF_SCAN;
            S_TF_SCAN: begin
                priority if (flags.to_over) begin
                    state_next = flags.can_fall ? S_TF_START : S_DONE;
                end else if (flags.head_empty) begin
                    state_next = S_TF_SCAN;
                end else begin
                    state_next = S_UNLINK;
                    uret_next  = URET_TAKE;
                end
            end
            S_TF_SPLIT: begin
                priority if (flags.split_more) begin
                    state_next = S_PUSH_HEAD;
                    pret_next  = PRET_SPLIT;
                end else if (flags.need_run) begin
                    state_next = S_RUN_ORDER;
                end else begin
                    state_next = S_TF_MARK;
                end
            end
            S_RUN_ORDER: begin
                if (!flags.run_grow) begin
                    state_next = S_MI_CHECK;
                    mret_next  = MRET_RUN;
                end
            end
            S_RUN_NEXT: state_next = flags.run_last ? S_TF_MARK : S_RUN_ORDER;
            S_TF_MARK: begin
                if (flags.mark_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (flags.out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        in_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR:      cmd = CMD_CLEAR;
            S_IDLE:       cmd = CMD_IDLE;
            S_DISPATCH:   cmd = CMD_DISPATCH;
            S_RC_UPDATE:  cmd = CMD_RC_UPDATE;
            S_FH_READ:    cmd = CMD_FH_READ;
            S_FH_MARK:    cmd = CMD_FH_MARK;
            S_RR_CHECK:   cmd = CMD_RR_CHECK;
            S_RR_CLEAR:   cmd = CMD_RR_CLEAR;
            S_RR_NEXT:    cmd = CMD_RR_NEXT;
            S_MI_CHECK:   cmd = CMD_MI_CHECK;
            S_MI_TEST:    cmd = CMD_MI_TEST;
            S_MI_ADVANCE: cmd = CMD_MI_ADVANCE;
            S_UNLINK:     cmd = CMD_UNLINK;
            S_PUSH_HEAD:  cmd = CMD_PUSH_HEAD;
            S_PUSH_LINK:  cmd = CMD_PUSH_LINK;
            S_TF_START:   cmd = CMD_TF_START;
            S_TF_SCAN:    cmd = CMD_TF_SCAN;
            S_TF_SPLIT:   cmd = CMD_TF_SPLIT;
            S_RUN_ORDER:  cmd = CMD_RUN_ORDER;
            S_RUN_NEXT:   cmd = CMD_RUN_NEXT;
            S_TF_MARK:    cmd = CMD_TF_MARK;
            S_DONE:       cmd = CMD_DONE;
            default:      cmd = CMD_CLEAR;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UNLINK && uret_reg == URET_TAKE) |=> state_reg == S_TF_SPLIT)
        else $error("unlink for a take did not return to the split step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request accepted during the clearing sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_DISPATCH)
        else $error("accepted request was not dispatched");

endmodule

FILE: sv/zbpa_datapath.sv
`timescale 1ns / 1ps

module zbpa_datapath
    import zbpa_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int TOP_ORDER = TOP_ORDER_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output dp_flags_t            flags,
    input  logic                 in_take,
    input  logic [FUNC_W-1:0]    in_func,
    input  logic [INDEX_W-1:0]   in_page_index,
    input  logic [COUNT_W-1:0]   in_page_count,
    input  logic                 in_low_zone_only,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INDEX_W-1:0]   out_result_page,
    output logic [STATUS_W-1:0]  out_status,
    output logic [COUNT_W-1:0]   out_free_total,
    output logic [COUNT_W-1:0]   out_managed_total
);

    localparam int PB    = PAGE_BITS;
    localparam int WW    = ((PB > COUNT_W) ? PB : COUNT_W) + 2;
    localparam int LW    = PB + 1;
    localparam int OW    = $clog2(TOP_ORDER + 2);
    localparam int MW    = $clog2(TOP_ORDER + 4);
    localparam int SLOTS = 2 * (TOP_ORDER + 1);
    localparam int SW    = $clog2(SLOTS);
    localparam logic [WW-1:0] ONE_W   = WW'(1);
    localparam logic [WW-1:0] DEPTH_W = ONE_W << PB;
    localparam logic [LW-1:0] NO_PAGE = {1'b1, {PB{1'b0}}};
    localparam logic [MW-1:0] MK_INTERIOR = MW'(TOP_ORDER + 1);
    localparam logic [MW-1:0] MK_ALLOC    = MW'(TOP_ORDER + 2);
    localparam logic [MW-1:0] MK_RESERVED = MW'(TOP_ORDER + 3);
    localparam logic [OW-1:0] TOP_O       = OW'(TOP_ORDER);

    logic [MW-1:0] mk_mem  [0:(64'd1 << PB) - 1];
    logic [31:0]   rc_mem  [0:(64'd1 << PB) - 1];
    logic [LW-1:0] nxt_mem [0:(64'd1 << PB) - 1];
    logic [LW-1:0] prv_mem [0:(64'd1 << PB) - 1];

    logic [MW-1:0] mk_q_reg;
    logic [31:0]   rc_q_reg;
    logic [LW-1:0] nxt_q_reg, prv_q_reg;

    logic [PB-1:0] mk_raddr, rc_raddr, nxt_raddr, prv_raddr;
    logic          mk_we, rc_we, nxt_we, prv_we;
    logic [PB-1:0] mk_waddr, rc_waddr, nxt_waddr, prv_waddr;
    logic [MW-1:0] mk_wdata;
    logic [31:0]   rc_wdata;
    logic [LW-1:0] nxt_wdata, prv_wdata;

    logic [FUNC_W-1:0]   func_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic                low_reg;
    logic [COUNT_W-1:0]  page_limit_reg, low_limit_reg;
    logic [COUNT_W-1:0]  free_reg, managed_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [PB-1:0]       result_reg;
    logic [WW-1:0]       ri_reg;
    logic [WW-1:0]       mp_reg;
    logic [OW-1:0]       mo_reg;
    logic                mz_reg;
    logic [PB-1:0]       ul_p_reg;
    logic [OW-1:0]       ul_o_reg;
    logic                ul_z_reg;
    logic [PB-1:0]       pu_p_reg;
    logic [OW-1:0]       pu_o_reg;
    logic                pu_z_reg;
    logic [LW-1:0]       pu_nx_reg;
    logic                tz_reg;
    logic [OW-1:0]       to_reg, twant_reg;
    logic [PB-1:0]       tp_reg;
    logic [WW-1:0]       rp_reg, rn_reg;
    logic [OW-1:0]       ro_reg;
    logic [COUNT_W-1:0]  mi_reg;
    logic [PB-1:0]       clr_reg;
    logic [LW-1:0]       head_reg [SLOTS];
    logic                m_valid_reg;
    logic [INDEX_W-1:0]  m_result_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_free_reg, m_managed_reg;

    logic [WW-1:0] lim_w, cnt_w, b_w, ns_w, run_step, mark_addr;
    logic [OW-1:0] want_c;
    logic [LW-1:0] scan_head;

    function automatic logic zone_f(input logic [WW-1:0] x, input logic [COUNT_W-1:0] lz);
        return !(x < WW'(lz));
    endfunction

    function automatic logic [SW-1:0] slot_f(input logic z, input logic [OW-1:0] o);
        logic [OW-1:0] oc;
        oc = (o > TOP_O) ? TOP_O : o;
        return (z ? SW'(TOP_ORDER + 1) : SW'(0)) + SW'(oc);
    endfunction

    always_comb begin
        want_c = '0;
        for (int k = 0; k < TOP_ORDER; k++) begin
            if ((ONE_W << k) < cnt_w) want_c = want_c + 1'b1;
        end
    end

    always_comb begin
        cnt_w     = WW'(cnt_reg);
        lim_w     = (WW'(page_limit_reg) < DEPTH_W) ? WW'(page_limit_reg) : DEPTH_W;
        b_w       = mp_reg ^ (ONE_W << mo_reg);
        ns_w      = ONE_W << (WW'(ro_reg) + ONE_W);
        run_step  = ONE_W << ro_reg;
        mark_addr = WW'(tp_reg) + WW'(mi_reg);
        scan_head = head_reg[slot_f(tz_reg, to_reg)];

        flags.func       = func_reg;
        flags.clr_last   = &clr_reg;
        flags.bad_alloc  = (cnt_reg == '0) || (cnt_w > lim_w) || (cnt_w > (ONE_W << TOP_ORDER));
        flags.idx_out    = WW'(idx_reg) >= lim_w;
        flags.cnt_zero   = (cnt_reg == '0);
        flags.rc_zero    = (rc_q_reg == 32'd0);
        flags.rc_one     = (rc_q_reg == 32'd1);
        flags.rr_end     = ri_reg >= (WW'(idx_reg) + cnt_w);
        flags.ri_in      = ri_reg < lim_w;
        flags.mi_stop    = (mo_reg >= TOP_O) || (b_w >= lim_w)
                           || (zone_f(b_w, low_limit_reg) != mz_reg);
        flags.mk_match   = (mk_q_reg == MW'(mo_reg));
        flags.to_over    = to_reg > TOP_O;
        flags.head_empty = (scan_head == NO_PAGE);
        flags.can_fall   = tz_reg && !low_reg;
        flags.split_more = to_reg > twant_reg;
        flags.need_run   = cnt_w < (ONE_W << twant_reg);
        flags.run_grow   = (ro_reg < TOP_O) && ((rp_reg & (ns_w - ONE_W)) == '0)
                           && (ns_w <= rn_reg)
                           && (zone_f(rp_reg, low_limit_reg)
                               == zone_f(rp_reg + ns_w - ONE_W, low_limit_reg));
        flags.run_last   = (rn_reg == run_step);
        flags.mark_last  = (mi_reg == cnt_reg - 1'b1);
        flags.out_free   = !m_valid_reg || out_ready;
    end

    always_comb begin
        mk_raddr  = PB'(ri_reg);
        rc_raddr  = PB'(ri_reg);
        nxt_raddr = PB'(b_w);
        prv_raddr = PB'(b_w);
        mk_we = 1'b0; rc_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0;
        mk_waddr  = PB'(ri_reg);
        rc_waddr  = PB'(ri_reg);
        nxt_waddr = pu_p_reg;
        prv_waddr = pu_p_reg;
        mk_wdata  = MK_ALLOC;
        rc_wdata  = 32'd1;
        nxt_wdata = nxt_q_reg;
        prv_wdata = prv_q_reg;
        unique case (cmd)
            CMD_CLEAR: begin
                mk_we = 1'b1; mk_waddr = clr_reg; mk_wdata = MK_RESERVED;
                rc_we = 1'b1; rc_waddr = clr_reg; rc_wdata = 32'd1;
            end
            CMD_DISPATCH: rc_raddr = PB'(WW'(idx_reg));
            CMD_RC_UPDATE: begin
                if (!flags.rc_zero) begin
                    if (func_reg == FN_DROP) begin
                        rc_we = 1'b1; rc_wdata = rc_q_reg - 32'd1;
                    end else if (rc_q_reg != 32'hFFFF_FFFF) begin
                        rc_we = 1'b1; rc_wdata = rc_q_reg + 32'd1;
                    end
                end
            end
            CMD_FH_MARK: begin
                mk_we = 1'b1; mk_wdata = MK_ALLOC;
            end
            CMD_RR_CLEAR: begin
                rc_we = !flags.rc_zero; rc_wdata = 32'd0;
            end
            CMD_MI_CHECK: mk_raddr = PB'(b_w);
            CMD_UNLINK: begin
                if (prv_q_reg != NO_PAGE) begin
                    nxt_we = 1'b1; nxt_waddr = prv_q_reg[PB-1:0]; nxt_wdata = nxt_q_reg;
                end
                if (nxt_q_reg != NO_PAGE) begin
                    prv_we = 1'b1; prv_waddr = nxt_q_reg[PB-1:0]; prv_wdata = prv_q_reg;
                end
                mk_we = 1'b1; mk_waddr = ul_p_reg; mk_wdata = MK_INTERIOR;
            end
            CMD_PUSH_HEAD: begin
                prv_we = 1'b1; prv_waddr = pu_p_reg; prv_wdata = NO_PAGE;
                nxt_we = 1'b1; nxt_waddr = pu_p_reg;
                nxt_wdata = head_reg[slot_f(pu_z_reg, pu_o_reg)];
                mk_we = 1'b1; mk_waddr = pu_p_reg; mk_wdata = MW'(pu_o_reg);
            end
            CMD_PUSH_LINK: begin
                if (pu_nx_reg != NO_PAGE) begin
                    prv_we = 1'b1; prv_waddr = pu_nx_reg[PB-1:0];
                    prv_wdata = {1'b0, pu_p_reg};
                end
            end
            CMD_TF_SCAN: begin
                nxt_raddr = scan_head[PB-1:0];
                prv_raddr = scan_head[PB-1:0];
            end
            CMD_TF_MARK: begin
                mk_we = 1'b1; mk_waddr = PB'(mark_addr); mk_wdata = MK_ALLOC;
                rc_we = 1'b1; rc_waddr = PB'(mark_addr); rc_wdata = 32'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mk_q_reg  <= mk_mem[mk_raddr];
        rc_q_reg  <= rc_mem[rc_raddr];
        nxt_q_reg <= nxt_mem[nxt_raddr];
        prv_q_reg <= prv_mem[prv_raddr];
        if (mk_we)  mk_mem[mk_waddr]   <= mk_wdata;
        if (rc_we)  rc_mem[rc_waddr]   <= rc_wdata;
        if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
        if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SLOTS; s++) head_reg[s] <= NO_PAGE;
            free_reg       <= '0;
            managed_reg    <= '0;
            page_limit_reg <= '0;
            low_limit_reg  <= COUNT_W'(1) << INDEX_W;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PAGE_LIMIT: page_limit_reg <= cfg_data;
                    REG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd == CMD_DONE && flags.out_free) begin
                m_valid_reg   <= 1'b1;
                m_result_reg  <= INDEX_W'(WW'(result_reg));
                m_status_reg  <= status_reg;
                m_free_reg    <= free_reg;
                m_managed_reg <= managed_reg;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd)
                CMD_CLEAR: clr_reg <= clr_reg + 1'b1;
                CMD_IDLE: begin
                    if (in_take) begin
                        func_reg <= in_func;
                        idx_reg  <= in_page_index;
                        cnt_reg  <= in_page_count;
                        low_reg  <= in_low_zone_only;
                    end
                end
                CMD_DISPATCH: begin
                    result_reg <= '0;
                    ri_reg     <= WW'(idx_reg);
                    tz_reg     <= !low_reg;
                    status_reg <= ST_OK;
                    unique case (func_reg)
                        FN_ALLOC:   if (flags.bad_alloc) status_reg <= ST_BAD_COUNT;
                        FN_RELEASE: if (flags.cnt_zero)  status_reg <= ST_NOT_HELD;
                        default:    if (flags.idx_out)   status_reg <= ST_NOT_HELD;
                    endcase
                end
                CMD_RC_UPDATE: begin
                    if (flags.rc_zero) begin
                        status_reg <= ST_NOT_HELD;
                    end else if (func_reg == FN_ADDREF && rc_q_reg == 32'hFFFF_FFFF) begin
                        status_reg <= ST_SATURATED;
                    end
                end
                CMD_FH_MARK: begin
                    if (mk_q_reg == MK_RESERVED) managed_reg <= managed_reg + 1'b1;
                    free_reg <= free_reg + 1'b1;
                    mp_reg   <= ri_reg;
                    mo_reg   <= '0;
                    mz_reg   <= zone_f(ri_reg, low_limit_reg);
                end
                CMD_RR_NEXT: ri_reg <= ri_reg + ONE_W;
                CMD_MI_CHECK: begin
                    pu_p_reg <= PB'(mp_reg);
                    pu_o_reg <= mo_reg;
                    pu_z_reg <= mz_reg;
                end
                CMD_MI_TEST: begin
                    ul_p_reg <= PB'(b_w);
                    ul_o_reg <= mo_reg;
                    ul_z_reg <= mz_reg;
                end
                CMD_UNLINK: begin
                    if (prv_q_reg == NO_PAGE) head_reg[slot_f(ul_z_reg, ul_o_reg)] <= nxt_q_reg;
                end
                CMD_MI_ADVANCE: begin
                    if (WW'(ul_p_reg) < mp_reg) mp_reg <= WW'(ul_p_reg);
                    mo_reg <= mo_reg + 1'b1;
                end
                CMD_PUSH_HEAD: begin
                    head_reg[slot_f(pu_z_reg, pu_o_reg)] <= {1'b0, pu_p_reg};
                    pu_nx_reg <= head_reg[slot_f(pu_z_reg, pu_o_reg)];
                end
                CMD_TF_START: begin
                    to_reg    <= want_c;
                    twant_reg <= want_c;
                end
                CMD_TF_SCAN: begin
                    priority if (flags.to_over) begin
                        if (flags.can_fall) tz_reg <= 1'b0;
                        else status_reg <= ST_NO_MEMORY;
                    end else if (flags.head_empty) begin
                        to_reg <= to_reg + 1'b1;
                    end else begin
                        tp_reg   <= scan_head[PB-1:0];
                        ul_p_reg <= scan_head[PB-1:0];
                        ul_o_reg <= to_reg;
                        ul_z_reg <= tz_reg;
                    end
                end
                CMD_TF_SPLIT: begin
                    if (flags.split_more) begin
                        to_reg   <= to_reg - 1'b1;
                        pu_p_reg <= PB'(WW'(tp_reg) + (ONE_W << (to_reg - 1'b1)));
                        pu_o_reg <= to_reg - 1'b1;
                        pu_z_reg <= tz_reg;
                    end else begin
                        mi_reg <= '0;
                        rp_reg <= WW'(tp_reg) + cnt_w;
                        rn_reg <= (ONE_W << twant_reg) - cnt_w;
                        ro_reg <= '0;
                    end
                end
                CMD_RUN_ORDER: begin
                    if (flags.run_grow) begin
                        ro_reg <= ro_reg + 1'b1;
                    end else begin
                        mp_reg <= rp_reg;
                        mo_reg <= ro_reg;
                        mz_reg <= zone_f(rp_reg, low_limit_reg);
                    end
                end
                CMD_RUN_NEXT: begin
                    rp_reg <= rp_reg + run_step;
                    rn_reg <= rn_reg - run_step;
                    ro_reg <= '0;
                end
                CMD_TF_MARK: begin
                    mi_reg <= mi_reg + 1'b1;
                    if (flags.mark_last) begin
                        free_reg   <= free_reg - cnt_reg;
                        result_reg <= tp_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign out_valid         = m_valid_reg;
    assign out_result_page   = m_result_reg;
    assign out_status        = m_status_reg;
    assign out_free_total    = m_free_reg;
    assign out_managed_total = m_managed_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_PUSH_HEAD) |-> (pu_o_reg <= TOP_O))
        else $error("free block pushed with an order above the top order");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_TF_MARK) |-> (mi_reg < cnt_reg))
        else $error("allocation marking ran past the requested count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_MI_CHECK) |-> (mo_reg <= TOP_O))
        else $error("coalescing order above the top order");

endmodule

FILE: sv/zoned_buddy_page_allocator_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_tvalid/s_tready  | s_tdata, s_tuser (one request)
// m_       | out       | m_tvalid/m_tready  | m_tdata (one result per request)
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// After reset a clearing sweep marks every page reserved, one page a cycle,
// and no request is taken until it ends.
// A reference request that frees nothing passes through dispatch, count update and done
// before the next acceptance, its result loaded in the done state; an allocation scans,
// splits or merges order by order and then marks each allocated page in turn; a range
// release checks each page in turn plus its coalescing steps.
// Each step is bounded by one read and one write per cycle on each page store.
// A request is taken while a finished result still waits on m_.

module zoned_buddy_page_allocator_top
    import zbpa_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int TOP_ORDER = TOP_ORDER_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // page_index[19:0], page_count[40:20], zero fill
    input  logic [47:0]          s_tdata,
    // func[1:0], low_zone_only[2]
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_page[19:0], status[22:20], free_total[43:23], managed_total[64:44]
    output logic [71:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    cmd_t      cmd;
    dp_flags_t flags;
    logic [INDEX_W-1:0]  result_page;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_total, managed_total;

    assign cfg_ready = 1'b1;

    zbpa_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    zbpa_datapath #(
        .PAGE_BITS (PAGE_BITS),
        .TOP_ORDER (TOP_ORDER)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .flags             (flags),
        .in_take           (s_tvalid && s_tready),
        .in_func           (s_tuser[1:0]),
        .in_page_index     (s_tdata[19:0]),
        .in_page_count     (s_tdata[40:20]),
        .in_low_zone_only  (s_tuser[2]),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_result_page   (result_page),
        .out_status        (status),
        .out_free_total    (free_total),
        .out_managed_total (managed_total)
    );

    assign m_tdata = {7'd0, managed_total, free_total, status, result_page};

endmodule
